// ===== design/pbrs_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the
// patch-budget resize block. No dependencies.
package pbrs_pkg;

   // Geometry and budget
   localparam int PATCH_SIZE   = 16;
   localparam int POOL_KERNEL  = 3;
   localparam int TOKEN_BUDGET = 280;
   localparam int GROUP_SIDE   = PATCH_SIZE * POOL_KERNEL;
   localparam int MAX_SIDE     = TOKEN_BUDGET * GROUP_SIDE;
   localparam int BUDGET_PIX   = TOKEN_BUDGET * GROUP_SIDE * GROUP_SIDE;

   // Field and internal widths
   localparam int IN_W    = 16;
   localparam int OUT_W   = 14;
   localparam int BIT_W   = 4;                  // index of a root bit / divide step
   localparam int SIDE_W  = 22;                 // k * GROUP_SIDE for any 16-bit k
   localparam int SQ_W    = 2 * IN_W;           // trial squared
   localparam int PROD_W  = SQ_W + IN_W;        // trial squared times other side
   localparam int LIMIT_W = 25;                 // TOKEN_BUDGET times a 16-bit side
   localparam int AREA_W  = 2 * OUT_W;          // product of two output sides
   localparam int OUT_MAX = (1 << OUT_W) - 1;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_ZERO_DIM = 2'd1,
      STAT_ASPECT   = 2'd2,
      STAT_OVER     = 2'd3
   } status_type;

   // Which result the datapath latches when told to emit
   typedef enum logic [1:0] {
      EMIT_ZERO,
      EMIT_ASPECT,
      EMIT_CHECK
   } emit_sel_type;

   typedef struct packed {
      logic             load;
      logic             sq_step;
      logic             cmp_step;
      logic             scale;
      logic             div_step;
      logic             div_end;
      logic             check;
      logic             emit;
      emit_sel_type     emit_sel;
      logic [BIT_W-1:0] bit_idx;
   } cmd_type;

   typedef struct packed {
      logic in_zero;
      logic kw_zero;
      logic kh_zero;
   } dp_stat_type;

endpackage

// ===== design/patch_budget_resize_size_top.sv =====
// Patch-budget resize target: top level joining controller and datapath.
// Depends on pbrs_pkg, pbrs_ctrl and pbrs_dp.
//
// Usage:
//   Request: drive req_image_width/req_image_height and raise start; the
//   request is taken at a clock edge where start is high and busy is low.
//   Response: rsp_valid is high for exactly one cycle with rsp_resized_width,
//   rsp_resized_height and rsp_status; the receiver cannot stall it.
// Sequence from request to strobe, by case:
//   zero dimension        answered straight from idle
//   both sides zero groups root search, then scale
//   normal                root search, scale, check, final
//   one side zero groups  root search, scale, divide, divide end, check, final
// The 16-bit root search squares, then multiplies and compares, bit by bit,
// both sides in parallel; the one-group case adds a 16-step
// restoring divider. One request is in flight at a time; busy drops in the
// cycle the strobe shows, so the next request may be taken then.
// Reset: synchronous, returns to idle with no strobe pending.
module patch_budget_resize_size_top import pbrs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [IN_W-1:0]  req_image_width,
   input  logic [IN_W-1:0]  req_image_height,
   output logic             rsp_valid,
   output logic [OUT_W-1:0] rsp_resized_width,
   output logic [OUT_W-1:0] rsp_resized_height,
   output logic [1:0]       rsp_status
);

   cmd_type     cmd;
   dp_stat_type stat;
   status_type  res_status;

   pbrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   pbrs_dp u_dp (
      .clock            (clock),
      .req_image_width  (req_image_width),
      .req_image_height (req_image_height),
      .cmd              (cmd),
      .stat             (stat),
      .res_width        (rsp_resized_width),
      .res_height       (rsp_resized_height),
      .res_status       (res_status)
   );

   assign rsp_status = res_status;

endmodule

// ===== design/pbrs_dp.sv =====
// Datapath: square-root search on both sides, restoring divider for the
// one-group case, budget check and result registers. Uses pbrs_pkg.
module pbrs_dp import pbrs_pkg::*; (
   input  logic                 clock,
   input  logic [IN_W-1:0]      req_image_width,
   input  logic [IN_W-1:0]      req_image_height,
   input  cmd_type              cmd,
   output dp_stat_type          stat,
   output logic [OUT_W-1:0]     res_width,
   output logic [OUT_W-1:0]     res_height,
   output status_type           res_status
);

   logic [IN_W-1:0]    w_ff, h_ff;
   logic [IN_W-1:0]    kw_ff, kh_ff, kw_in, kh_in;
   logic [SQ_W-1:0]    sqw_ff, sqh_ff, sqw_in, sqh_in;
   logic [SIDE_W-1:0]  tw_ff, th_ff, tw_in, th_in;
   logic               div_to_h_ff, div_to_h_in;
   logic [IN_W-1:0]    quo_ff, quo_in, rem_ff, rem_in, den_ff, den_in;
   logic               fit_ff, fit_in;
   logic [AREA_W-1:0]  area_ff, area_in;
   logic [OUT_W-1:0]   res_w_ff, res_h_ff, res_w_in, res_h_in;
   status_type         res_st_ff, res_st_in;

   logic [IN_W-1:0]    trial_w, trial_h;
   logic [LIMIT_W-1:0] limit_w, limit_h;
   logic [PROD_W-1:0]  prod_w, prod_h;
   logic [IN_W:0]      div_r;
   logic               div_ge;
   logic [SIDE_W-1:0]  div_side, div_scaled;

   // Trial root for the current bit, per side
   assign trial_w = kw_ff | (IN_W'(1) << cmd.bit_idx);
   assign trial_h = kh_ff | (IN_W'(1) << cmd.bit_idx);

   // Budget limit per side: TOKEN_BUDGET * this side
   assign limit_w = LIMIT_W'(w_ff) * LIMIT_W'(TOKEN_BUDGET);
   assign limit_h = LIMIT_W'(h_ff) * LIMIT_W'(TOKEN_BUDGET);
   assign prod_w  = PROD_W'(sqw_ff) * PROD_W'(h_ff);
   assign prod_h  = PROD_W'(sqh_ff) * PROD_W'(w_ff);

   // One restoring divide step
   assign div_r  = {rem_ff, quo_ff[IN_W-1]};
   assign div_ge = (div_r >= {1'b0, den_ff});

   // Quotient scaled to pixels and capped at the maximum side
   assign div_scaled = SIDE_W'(quo_ff) * SIDE_W'(GROUP_SIDE);
   assign div_side   = (div_scaled > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : div_scaled;

   assign stat.in_zero = (req_image_width == '0) || (req_image_height == '0);
   assign stat.kw_zero = (kw_ff == '0);
   assign stat.kh_zero = (kh_ff == '0);

   always_comb begin
      kw_in       = kw_ff;
      kh_in       = kh_ff;
      sqw_in      = sqw_ff;
      sqh_in      = sqh_ff;
      tw_in       = tw_ff;
      th_in       = th_ff;
      div_to_h_in = div_to_h_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      den_in      = den_ff;
      fit_in      = fit_ff;
      area_in     = area_ff;
      res_w_in    = res_w_ff;
      res_h_in    = res_h_ff;
      res_st_in   = res_st_ff;

      if (cmd.load) begin
         kw_in = '0;
         kh_in = '0;
      end

      // Square the trial roots
      if (cmd.sq_step) begin
         sqw_in = SQ_W'(trial_w) * SQ_W'(trial_w);
         sqh_in = SQ_W'(trial_h) * SQ_W'(trial_h);
      end

      // Keep the trial bit where the squared root still fits
      if (cmd.cmp_step) begin
         if (prod_w <= PROD_W'(limit_w)) kw_in = trial_w;
         if (prod_h <= PROD_W'(limit_h)) kh_in = trial_h;
      end

      // Scale roots to pixels; a zero side becomes one group and sets up the divide
      if (cmd.scale) begin
         tw_in       = stat.kw_zero ? SIDE_W'(GROUP_SIDE) : SIDE_W'(kw_ff) * SIDE_W'(GROUP_SIDE);
         th_in       = stat.kh_zero ? SIDE_W'(GROUP_SIDE) : SIDE_W'(kh_ff) * SIDE_W'(GROUP_SIDE);
         div_to_h_in = stat.kw_zero;
         quo_in      = stat.kw_zero ? h_ff : w_ff;
         den_in      = stat.kw_zero ? w_ff : h_ff;
         rem_in      = '0;
      end

      if (cmd.div_step) begin
         rem_in = div_ge ? IN_W'(div_r - {1'b0, den_ff}) : div_r[IN_W-1:0];
         quo_in = {quo_ff[IN_W-2:0], div_ge};
      end

      if (cmd.div_end) begin
         if (div_to_h_ff) th_in = div_side;
         else             tw_in = div_side;
      end

      // Field fit and area of the candidate result
      if (cmd.check) begin
         fit_in  = (tw_ff != '0) && (th_ff != '0) &&
                   (tw_ff <= SIDE_W'(OUT_MAX)) && (th_ff <= SIDE_W'(OUT_MAX));
         area_in = AREA_W'(tw_ff[OUT_W-1:0]) * AREA_W'(th_ff[OUT_W-1:0]);
      end

      if (cmd.emit) begin
         res_w_in = '0;
         res_h_in = '0;
         case (cmd.emit_sel)
            EMIT_ZERO:   res_st_in = STAT_ZERO_DIM;
            EMIT_ASPECT: res_st_in = STAT_ASPECT;
            EMIT_CHECK: begin
               if (fit_ff && (area_ff <= AREA_W'(BUDGET_PIX))) begin
                  res_st_in = STAT_OK;
                  res_w_in  = tw_ff[OUT_W-1:0];
                  res_h_in  = th_ff[OUT_W-1:0];
               end else begin
                  res_st_in = STAT_OVER;
               end
            end
            default:     res_st_in = STAT_OVER;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         w_ff <= req_image_width;
         h_ff <= req_image_height;
      end
      kw_ff       <= kw_in;
      kh_ff       <= kh_in;
      sqw_ff      <= sqw_in;
      sqh_ff      <= sqh_in;
      tw_ff       <= tw_in;
      th_ff       <= th_in;
      div_to_h_ff <= div_to_h_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      fit_ff      <= fit_in;
      area_ff     <= area_in;
      res_w_ff    <= res_w_in;
      res_h_ff    <= res_h_in;
      res_st_ff   <= res_st_in;
   end

   assign res_width  = res_w_ff;
   assign res_height = res_h_ff;
   assign res_status = res_st_ff;

endmodule

// ===== design/pbrs_ctrl.sv =====
// Controller FSM: sequences root search, divide, budget check and result
// strobe. Uses pbrs_pkg.
module pbrs_ctrl import pbrs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  dp_stat_type stat,
   output cmd_type     cmd,
   output logic        busy,
   output logic        rsp_valid
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ,
      ST_CMP,
      ST_SCALE,
      ST_DIV,
      ST_DIV_END,
      ST_CHECK,
      ST_FINAL
   } state_type;

   state_type        state_ff, state_in;
   logic [BIT_W-1:0] cnt_ff, cnt_in;
   logic             valid_ff, valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      valid_in     = 1'b0;
      cmd          = '0;
      cmd.emit_sel = EMIT_CHECK;
      cmd.bit_idx  = cnt_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (stat.in_zero) begin
                  cmd.emit     = 1'b1;
                  cmd.emit_sel = EMIT_ZERO;
                  valid_in     = 1'b1;
               end else begin
                  cnt_in   = '1;
                  state_in = ST_SQ;
               end
            end
         end
         ST_SQ: begin
            cmd.sq_step = 1'b1;
            state_in    = ST_CMP;
         end
         ST_CMP: begin
            cmd.cmp_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            state_in     = (cnt_ff == '0) ? ST_SCALE : ST_SQ;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            if (stat.kw_zero && stat.kh_zero) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = EMIT_ASPECT;
               valid_in     = 1'b1;
               state_in     = ST_IDLE;
            end else if (stat.kw_zero || stat.kh_zero) begin
               cnt_in   = '1;
               state_in = ST_DIV;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = ST_DIV_END;
         end
         ST_DIV_END: begin
            cmd.div_end = 1'b1;
            state_in    = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_FINAL;
         end
         ST_FINAL: begin
            cmd.emit = 1'b1;
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule

// ===== design/pbrs_checker.sv =====
// Port-level checks for the resize block, bound to the top level.
// Depends on pbrs_pkg and patch_budget_resize_size_top.
module pbrs_checker import pbrs_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic [IN_W-1:0]  req_image_width,
   input logic [IN_W-1:0]  req_image_height,
   input logic             rsp_valid,
   input logic [OUT_W-1:0] rsp_resized_width,
   input logic [OUT_W-1:0] rsp_resized_height,
   input logic [1:0]       rsp_status
);

   // After reset: idle, no strobe
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("not idle after reset");

   // A zero dimension answers on the next cycle with zero sizes
   a_zero_fast: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_image_width == '0 || req_image_height == '0)) |=>
      (rsp_valid && rsp_status == STAT_ZERO_DIM &&
       rsp_resized_width == '0 && rsp_resized_height == '0))
      else $error("zero dimension not reported");

   // Error responses carry zero sizes, good ones nonzero sizes
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STAT_OK) |->
      (rsp_resized_width == '0 && rsp_resized_height == '0))
      else $error("error response with nonzero size");

   a_ok_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_OK) |->
      (rsp_resized_width != '0 && rsp_resized_height != '0))
      else $error("ok response with zero size");

   // The strobe only shows once the block is ready again
   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("strobe while busy");

endmodule

bind patch_budget_resize_size_top pbrs_checker u_pbrs_checker (.*);

// ===== bench/tb_patch_budget_resize_size_top.sv =====
// Testbench for patch_budget_resize_size_top: sends image sizes and checks each
// resize target, field by field, against a behavioral predictor of the block.
// Depends on pbrs_pkg and the design sources.
module tb_patch_budget_resize_size_top import pbrs_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_COUNT  = 1500;
   localparam int TAIL_CYCLES   = 80;
   localparam int REPORT_LIMIT  = 10;

   // One image size request and the idling that precedes it
   typedef struct {
      logic [IN_W-1:0] w;
      logic [IN_W-1:0] h;
      int unsigned     gap;
      bit              drain;
   } size_req_type;

   // One resize target
   typedef struct {
      logic [OUT_W-1:0] width;
      logic [OUT_W-1:0] height;
      status_type       status;
   } target_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [IN_W-1:0]  req_image_width = '0;
   logic [IN_W-1:0]  req_image_height = '0;
   logic             rsp_valid;
   logic [OUT_W-1:0] rsp_resized_width;
   logic [OUT_W-1:0] rsp_resized_height;
   logic [1:0]       rsp_status;

   size_req_type pending_requests[$];
   target_type   expected_targets[$];
   size_req_type staged_req;
   bit           staged = 1'b0;
   int unsigned  idle_left = 0;
   int unsigned  mismatches = 0;
   int unsigned  cycles = 0;

   patch_budget_resize_size_top u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_image_width    (req_image_width),
      .req_image_height   (req_image_height),
      .rsp_valid          (rsp_valid),
      .rsp_resized_width  (rsp_resized_width),
      .rsp_resized_height (rsp_resized_height),
      .rsp_status         (rsp_status)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Largest k with k*k*across <= TOKEN_BUDGET*along, searched bit by bit
   function automatic longint unsigned groups_fit(longint unsigned along,
                                                  longint unsigned across);
      longint unsigned lim;
      longint unsigned k;
      longint unsigned t;
      int              b;
      lim = longint'(TOKEN_BUDGET) * along;
      k = 0;
      for (b = IN_W - 1; b >= 0; b--) begin
         t = k | (64'd1 << b);
         if (t * t * across <= lim)
            k = t;
      end
      return k;
   endfunction

   function automatic target_type resize_target(logic [IN_W-1:0] w, logic [IN_W-1:0] h);
      longint unsigned tw;
      longint unsigned th;
      longint unsigned grp;
      target_type      r;
      grp = longint'(GROUP_SIDE);
      r.width = '0;
      r.height = '0;
      r.status = STAT_OK;
      if (w == 0 || h == 0) begin
         r.status = STAT_ZERO_DIM;
         return r;
      end
      tw = groups_fit(w, h) * grp;
      th = groups_fit(h, w) * grp;
      if (tw == 0 && th == 0) begin
         r.status = STAT_ASPECT;
         return r;
      end
      // a side with no whole group falls back to one group, the other to the ratio
      if (tw == 0) begin
         tw = grp;
         th = (longint'(h) / longint'(w)) * grp;
         if (th > longint'(MAX_SIDE))
            th = longint'(MAX_SIDE);
      end else if (th == 0) begin
         th = grp;
         tw = (longint'(w) / longint'(h)) * grp;
         if (tw > longint'(MAX_SIDE))
            tw = longint'(MAX_SIDE);
      end
      if (tw == 0 || th == 0 || tw > longint'(OUT_MAX) || th > longint'(OUT_MAX) ||
          tw * th > longint'(BUDGET_PIX)) begin
         r.status = STAT_OVER;
      end else begin
         r.width = tw[OUT_W-1:0];
         r.height = th[OUT_W-1:0];
      end
      return r;
   endfunction

   // Mostly no gap, often a short one, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic size_req_type random_size(int unsigned idx);
      size_req_type q;
      int unsigned  kind;
      int           a;
      int           b;
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
         // full range
         a = $urandom_range(0, 65535);
         b = $urandom_range(0, 65535);
      end else if (kind < 45) begin
         // mostly thin images: one side often gets no whole group
         a = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 8) : $urandom_range(1, 300);
         b = $urandom_range(1, 65535);
      end else if (kind < 65) begin
         // aspect ratio near the one-group boundary
         a = $urandom_range(1, 234);
         b = a * TOKEN_BUDGET + $urandom_range(0, 2 * a + 4) - (a + 2);
         if (b < 1) b = 1;
         if (b > 65535) b = 65535;
      end else if (kind < 85) begin
         a = $urandom_range(1, 2000);
         b = $urandom_range(1, 2000);
      end else if (kind < 95) begin
         // close to square
         a = $urandom_range(1, 65535);
         b = a + $urandom_range(0, 64) - 32;
         if (b < 1) b = 1;
         if (b > 65535) b = 65535;
      end else begin
         a = 0;
         b = $urandom_range(0, 65535);
      end
      if ($urandom_range(0, 1) != 0) begin
         q.w = a[IN_W-1:0];
         q.h = b[IN_W-1:0];
      end else begin
         q.w = b[IN_W-1:0];
         q.h = a[IN_W-1:0];
      end
      // every fourth block of fifty goes back to back
      q.gap = ((idx / 50) % 4 == 3) ? 0 : pick_gap();
      q.drain = ($urandom_range(0, 99) == 0);
      return q;
   endfunction

   function automatic size_req_type fixed_size(int unsigned w, int unsigned h);
      size_req_type q;
      q.w = w[IN_W-1:0];
      q.h = h[IN_W-1:0];
      q.gap = pick_gap();
      q.drain = 1'b0;
      return q;
   endfunction

   // Append a request to the pending list
   function automatic void add_request(size_req_type q);
      pending_requests = {pending_requests, q};
   endfunction

   // Request driver: holds start until taken, then stages the next request
   always @(posedge clock) begin
      logic offer;
      if (reset) begin
         start <= 1'b0;
         req_image_width <= '0;
         req_image_height <= '0;
         staged = 1'b0;
         idle_left = 0;
      end else begin
         if (start && !busy)
            expected_targets = {expected_targets,
                                resize_target(req_image_width, req_image_height)};
         offer = start && busy;
         if (!offer) begin
            if (!staged && pending_requests.size() != 0) begin
               staged_req = pending_requests.pop_front();
               staged = 1'b1;
               idle_left = staged_req.gap;
            end
            if (staged) begin
               if (idle_left != 0) begin
                  idle_left--;
               end else if (!staged_req.drain ||
                            (expected_targets.size() == 0 && !rsp_valid)) begin
                  req_image_width <= staged_req.w;
                  req_image_height <= staged_req.h;
                  offer = 1'b1;
                  staged = 1'b0;
               end
            end
         end
         start <= offer;
      end
   end

   // Result monitor
   always @(posedge clock) begin
      target_type exp_t;
      if (!reset && rsp_valid) begin
         if (expected_targets.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result: width %0d height %0d status %0d",
                        rsp_resized_width, rsp_resized_height, rsp_status);
         end else begin
            exp_t = expected_targets.pop_front();
            if (rsp_resized_width !== exp_t.width || rsp_resized_height !== exp_t.height ||
                rsp_status !== exp_t.status) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("mismatch: expected %0d x %0d status %0d, got %0d x %0d status %0d",
                           exp_t.width, exp_t.height, exp_t.status, rsp_resized_width,
                           rsp_resized_height, rsp_status);
            end
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      size_req_type q;
      int unsigned  i;

      // directed: zero sizes, extremes, one-group boundary, common shapes
      add_request(fixed_size(0, 0));
      add_request(fixed_size(0, 65535));
      add_request(fixed_size(65535, 0));
      add_request(fixed_size(1, 1));
      add_request(fixed_size(65535, 65535));
      add_request(fixed_size(1, 65535));
      add_request(fixed_size(65535, 1));
      add_request(fixed_size(1, 280));
      add_request(fixed_size(280, 1));
      add_request(fixed_size(1, 281));
      add_request(fixed_size(281, 1));
      add_request(fixed_size(48, 48));
      add_request(fixed_size(1920, 1080));
      add_request(fixed_size(1080, 1920));
      add_request(fixed_size(4096, 2160));
      add_request(fixed_size(3, 841));
      add_request(fixed_size(100, 28000));
      add_request(fixed_size(28001, 100));
      add_request(fixed_size(2, 65535));
      add_request(fixed_size(65534, 3));
      add_request(fixed_size(32768, 32767));
      add_request(fixed_size(21845, 43690));
      add_request(fixed_size(768, 768));

      // random part; the first one waits for the block to run dry
      for (i = 0; i < RANDOM_COUNT; i++) begin
         q = random_size(i);
         if (i == 0)
            q.drain = 1'b1;
         add_request(q);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || staged || start ||
             expected_targets.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      // a request still waiting for its result counts as lost
      if (mismatches == 0 && expected_targets.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
